// File: rtl/aabbs_pkg.sv
// ----------------------------------------------------------------------------
// aabbs_pkg
// Shared constants, codes and control structs for the body separation block.
// ----------------------------------------------------------------------------
package aabbs_pkg;

  localparam int MAX_BODIES = 16;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int BOX_W      = 6 * 32;
  localparam int ACC_W      = 32 + IDX_W + 1;
  localparam int DIV_STEPS  = 32;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic in_load;    // latch accepted beat
    logic exec;       // run add/remove/update, settle status, clear sums
    logic rd_en;      // table read
    logic rd_me;      // read address is queried slot, else scan index
    logic lat_me;     // capture queried body
    logic lat_o;      // capture other body
    logic o_clr;
    logic o_inc;
    logic calc_depth;
    logic pick;
    logic mul;
    logic div_init;
    logic div_step;
    logic acc;
    logic out_load;
  } aabbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       id_found;
    logic       o_take;   // scan slot is valid and carries another id
    logic       o_last;
    logic       hit;      // strict overlap on all axes
  } aabbs_sts_t;

endpackage

// File: rtl/aabbs_ram.sv
// ----------------------------------------------------------------------------
// aabbs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module aabbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/aabbs_ctrl.sv
// ----------------------------------------------------------------------------
// aabbs_ctrl
// Sequencer: command dispatch, slot scan, divide loop and result hand-off.
// ----------------------------------------------------------------------------
module aabbs_ctrl
  import aabbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  aabbs_sts_t sts_i,
  output aabbs_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_ME     = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_OWAIT  = 4'd4;
  localparam logic [3:0] S_DEPTH  = 4'd5;
  localparam logic [3:0] S_PICK   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DINIT  = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_ACC    = 4'd10;
  localparam logic [3:0] S_RESULT = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              oval_q, oval_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q;
    dcnt_d  = dcnt_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec  = 1'b1;
        cmd_o.o_clr = 1'b1;
        if (sts_i.cmd == CMD_QUERY && sts_i.id_found) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_me = 1'b1;
          state_d     = S_ME;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_ME: begin
        cmd_o.lat_me = 1'b1;
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.o_take) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_OWAIT;
        end else if (sts_i.o_last) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.o_inc = 1'b1;
        end
      end
      S_OWAIT: begin
        cmd_o.lat_o = 1'b1;
        state_d     = S_DEPTH;
      end
      S_DEPTH: begin
        cmd_o.calc_depth = 1'b1;
        state_d          = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        if (sts_i.hit) begin
          state_d = S_MUL;
        end else if (sts_i.o_last) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.o_inc = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        dcnt_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.o_last) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.o_inc = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_RESULT: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dcnt_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      oval_q  <= oval_d;
    end
  end

endmodule

// File: rtl/aabbs_dp.sv
// ----------------------------------------------------------------------------
// aabbs_dp
// Body table, overlap depth, mass share multiply/divide, axis sums, result.
// ----------------------------------------------------------------------------
module aabbs_dp
  import aabbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aabbs_cmd_t        cmd_i,
  output aabbs_sts_t        sts_o,
  input  logic [1:0]        in_cmd_i,
  input  logic [31:0]       in_id_i,
  input  logic [BOX_W-1:0]  in_box_i,
  input  logic [31:0]       in_mass_i,
  output logic [1:0]        out_status_o,
  output logic [31:0]       out_assigned_o,
  output logic [31:0]       out_push_x_o,
  output logic [31:0]       out_push_y_o,
  output logic [31:0]       out_push_z_o
);

  // latched command beat
  logic [1:0]       cmd_q;
  logic [31:0]      qid_q;
  logic [BOX_W-1:0] box_q;
  logic [31:0]      mass_q;

  // table: valid bits and ids in flops, boxes and masses in RAM
  logic             valid_q [MAX_BODIES];
  logic [31:0]      id_q    [MAX_BODIES];
  logic [31:0]      next_id_q;

  logic [MAX_BODIES-1:0] match;
  logic                  free_found, id_found;
  logic [IDX_W-1:0]      free_idx, hit_idx, o_idx_q;

  always_comb begin
    free_found = 1'b0;
    id_found   = 1'b0;
    free_idx   = '0;
    hit_idx    = '0;
    for (int i = MAX_BODIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (id_q[i] == qid_q);
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (match[i]) begin
        id_found = 1'b1;
        hit_idx  = IDX_W'(i);
      end
    end
  end

  logic             do_add, do_upd;
  logic             box_we, mass_we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [BOX_W-1:0] box_rd;
  logic [31:0]      mass_rd;

  assign do_add  = cmd_i.exec && (cmd_q == CMD_ADD) && free_found;
  assign do_upd  = cmd_i.exec && (cmd_q == CMD_UPDATE) && id_found;
  assign box_we  = do_add || do_upd;
  assign mass_we = do_add;
  assign waddr   = (cmd_q == CMD_ADD) ? free_idx : hit_idx;
  assign raddr   = cmd_i.rd_me ? hit_idx : o_idx_q;

  aabbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BODIES)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (waddr),
    .wdata_i (box_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (box_rd)
  );

  aabbs_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_mass_ram (
    .clk_i   (clk_i),
    .we_i    (mass_we),
    .waddr_i (waddr),
    .wdata_i (mass_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (mass_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cmd_q  <= in_cmd_i;
      qid_q  <= in_id_i;
      box_q  <= in_box_i;
      mass_q <= in_mass_i;
    end
    if (do_add) begin
      id_q[free_idx] <= next_id_q;
    end
  end

  logic [1:0]  res_status_q;
  logic [31:0] res_assigned_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BODIES; i++) begin
        valid_q[i] <= 1'b0;
      end
      next_id_q <= '0;
      o_idx_q   <= '0;
    end else begin
      if (do_add) begin
        valid_q[free_idx] <= 1'b1;
        next_id_q         <= next_id_q + 32'd1;
      end
      if (cmd_i.exec && cmd_q == CMD_REMOVE) begin
        for (int i = 0; i < MAX_BODIES; i++) begin
          if (match[i]) valid_q[i] <= 1'b0;
        end
      end
      if (cmd_i.o_clr) begin
        o_idx_q <= '0;
      end else if (cmd_i.o_inc) begin
        o_idx_q <= o_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_assigned_q <= '0;
      case (cmd_q)
        CMD_ADD: begin
          res_status_q <= free_found ? ST_DONE : ST_FULL;
          if (free_found) res_assigned_q <= next_id_q;
        end
        default: res_status_q <= id_found ? ST_DONE : ST_NOTFOUND;
      endcase
    end
  end

  // queried body and current other body
  logic signed [31:0] me_lo [3], me_hi [3], o_lo [3], o_hi [3];
  logic [31:0]        me_mass_q, o_mass_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_me) begin
      for (int a = 0; a < 3; a++) begin
        me_lo[a] <= box_rd[32*a +: 32];
        me_hi[a] <= box_rd[32*(a+3) +: 32];
      end
      me_mass_q <= mass_rd;
    end
    if (cmd_i.lat_o) begin
      for (int a = 0; a < 3; a++) begin
        o_lo[a] <= box_rd[32*a +: 32];
        o_hi[a] <= box_rd[32*(a+3) +: 32];
      end
      o_mass_q <= mass_rd;
    end
  end

  // overlap depth and direction per axis
  logic signed [32:0] d_q [3];
  logic               neg_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_depth) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [31:0] hi, lo;
        hi = (me_hi[a] < o_hi[a]) ? me_hi[a] : o_hi[a];
        lo = (me_lo[a] > o_lo[a]) ? me_lo[a] : o_lo[a];
        d_q[a]   <= 33'(hi) - 33'(lo);
        neg_q[a] <= (33'(me_lo[a]) + 33'(me_hi[a])) < (33'(o_lo[a]) + 33'(o_hi[a]));
      end
    end
  end

  // least-depth axis, lower axis on ties
  logic [1:0]  axis;
  logic [1:0]  axis_q;
  logic        sign_q;
  logic [31:0] dsel_q;
  logic [32:0] msum_q;

  always_comb begin
    axis = 2'd0;
    if (d_q[1] < d_q[0]) axis = 2'd1;
    if (d_q[2] < d_q[axis]) axis = 2'd2;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      axis_q <= axis;
      sign_q <= neg_q[axis];
      dsel_q <= d_q[axis][31:0];
      msum_q <= 33'(me_mass_q) + 33'(o_mass_q);
    end
  end

  // share = depth * other mass / mass sum; quotient fits 32 bits
  logic [63:0] prod_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q;
  logic [33:0] trial;

  assign trial = {rem_q, quo_q[31]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 64'(dsel_q) * 64'(o_mass_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= {1'b0, prod_q[63:32]};
      quo_q <= prod_q[31:0];
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, msum_q}) begin
        rem_q <= 33'(trial - {1'b0, msum_q});
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial[32:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // wide axis sums
  logic signed [ACC_W-1:0] acc_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int a = 0; a < 3; a++) acc_q[a] <= '0;
    end else if (cmd_i.acc && msum_q != '0) begin
      if (sign_q) begin
        acc_q[axis_q] <= acc_q[axis_q] - ACC_W'(quo_q);
      end else begin
        acc_q[axis_q] <= acc_q[axis_q] + ACC_W'(quo_q);
      end
    end
  end

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] vmax, vmin;
    vmax = ACC_W'(32'sh7fffffff);
    vmin = -ACC_W'(33'sh080000000);
    if (v > vmax)      sat32 = 32'h7fffffff;
    else if (v < vmin) sat32 = 32'h80000000;
    else               sat32 = v[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o   <= res_status_q;
      out_assigned_o <= res_assigned_q;
      out_push_x_o   <= sat32(acc_q[0]);
      out_push_y_o   <= sat32(acc_q[1]);
      out_push_z_o   <= sat32(acc_q[2]);
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.id_found = id_found;
  assign sts_o.o_take   = valid_q[o_idx_q] && (id_q[o_idx_q] != qid_q);
  assign sts_o.o_last   = (o_idx_q == IDX_W'(MAX_BODIES - 1));
  assign sts_o.hit      = (d_q[0] > 0) && (d_q[1] > 0) && (d_q[2] > 0);

endmodule

// File: rtl/aabb_body_separation.sv
// ----------------------------------------------------------------------------
// aabb_body_separation
// Body table with mass-weighted box separation push queries.
// ----------------------------------------------------------------------------
//  channel  | dir | tuser          | tdata (lowest bits first)
//  s_axis   | in  | command [1:0]  | body_id, min_x, min_y, min_z,
//           |     |                | max_x, max_y, max_z, mass (256 b)
//  m_axis   | out | status [1:0]   | assigned_id, push_x, push_y, push_z (128 b)
//
// Add, remove and update go from accept through the exec state to the result
// beat. A query of a known id scans every slot; each valid other body is read
// and its depth checked, and one that overlaps also runs the multiply and the
// 32-step shift-subtract divider before its push is added to the axis sums.
// Reset clears the valid bits and the id counter; no clearing pass.
// One beat in flight; the result waits in the output register, and a new
// beat is taken once the previous result has been moved there.
// ----------------------------------------------------------------------------
module aabb_body_separation
  import aabbs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // command
  input  logic [255:0] s_axis_tdata,   // body_id, min_x..z, max_x..z, mass
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [1:0]   m_axis_tuser,   // status
  output logic [127:0] m_axis_tdata    // assigned_id, push_x, push_y, push_z
);

  aabbs_cmd_t cmd;
  aabbs_sts_t sts;

  aabbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  aabbs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_cmd_i       (s_axis_tuser),
    .in_id_i        (s_axis_tdata[31:0]),
    .in_box_i       (s_axis_tdata[223:32]),
    .in_mass_i      (s_axis_tdata[255:224]),
    .out_status_o   (m_axis_tuser),
    .out_assigned_o (m_axis_tdata[31:0]),
    .out_push_x_o   (m_axis_tdata[63:32]),
    .out_push_y_o   (m_axis_tdata[95:64]),
    .out_push_z_o   (m_axis_tdata[127:96])
  );

endmodule

// File: rtl/aabbs_checker.sv
// ----------------------------------------------------------------------------
// aabbs_checker
// Port-level checks for the body separation block.
// ----------------------------------------------------------------------------
module aabbs_checker
  import aabbs_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [1:0]   m_axis_tuser,
  input logic [127:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_DONE || m_axis_tuser == ST_FULL ||
                       m_axis_tuser == ST_NOTFOUND))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == '0)
    else $error("failed command carries data");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

endmodule

bind aabb_body_separation aabbs_checker u_aabbs_checker (.*);

// File: bench/tb_aabb_body_separation.sv
// ----------------------------------------------------------------------------
// tb_aabb_body_separation
// Self-checking bench for the body separation block. Commands are driven on
// the input stream, a local body table predicts every result beat, and a
// checker compares status, id and the three pushes against that prediction.
// ----------------------------------------------------------------------------
module tb_aabb_body_separation
  import aabbs_pkg::*;
();

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic [31:0] push_x;
    logic [31:0] push_y;
    logic [31:0] push_z;
  } result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser;
  logic [255:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [1:0]   m_axis_tuser;
  logic [127:0] m_axis_tdata;

  aabb_body_separation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  // body table copy
  logic               bt_valid [MAX_BODIES];
  logic        [31:0] bt_id    [MAX_BODIES];
  logic signed [31:0] bt_lo    [MAX_BODIES][3];
  logic signed [31:0] bt_hi    [MAX_BODIES][3];
  logic        [31:0] bt_mass  [MAX_BODIES];
  logic        [31:0] bt_next_id;

  result_t expected_q[$];
  int      n_errors;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #80000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int find_body(logic [31:0] id);
    for (int i = 0; i < MAX_BODIES; i++)
      if (bt_valid[i] && bt_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [31:0] sat_q16(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // mass-weighted push for one queried slot
  function automatic result_t separation_push(int me);
    logic signed [63:0] tot [3];
    logic signed [63:0] d [3];
    logic signed [63:0] hi, lo;
    logic [63:0] msum, mag;
    logic hit;
    int ax;
    result_t r;
    for (int a = 0; a < 3; a++) tot[a] = 0;
    for (int o = 0; o < MAX_BODIES; o++) begin
      if (!bt_valid[o] || bt_id[o] == bt_id[me]) continue;
      hit = 1'b1;
      for (int a = 0; a < 3; a++) begin
        hi = (bt_hi[me][a] < bt_hi[o][a]) ? bt_hi[me][a] : bt_hi[o][a];
        lo = (bt_lo[me][a] > bt_lo[o][a]) ? bt_lo[me][a] : bt_lo[o][a];
        d[a] = hi - lo;
        if (d[a] <= 0) hit = 1'b0;
      end
      if (!hit) continue;
      ax = 0;
      if (d[1] < d[ax]) ax = 1;
      if (d[2] < d[ax]) ax = 2;
      msum = {32'd0, bt_mass[me]} + {32'd0, bt_mass[o]};
      mag = (msum != 0) ? (64'(d[ax]) * {32'd0, bt_mass[o]}) / msum : 64'd0;
      // centres compared as sums, 33-bit exact
      if (64'(bt_lo[me][ax]) + 64'(bt_hi[me][ax]) < 64'(bt_lo[o][ax]) + 64'(bt_hi[o][ax]))
        tot[ax] -= $signed(mag);
      else
        tot[ax] += $signed(mag);
    end
    r = '0;
    r.push_x = sat_q16(tot[0]);
    r.push_y = sat_q16(tot[1]);
    r.push_z = sat_q16(tot[2]);
    return r;
  endfunction

  function automatic result_t predict_body_cmd(logic [1:0] cmd, logic [255:0] td);
    result_t r;
    int s;
    logic any;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        s = -1;
        for (int i = 0; i < MAX_BODIES; i++)
          if (!bt_valid[i] && s < 0) s = i;
        if (s < 0) r.status = ST_FULL;
        else begin
          bt_valid[s] = 1'b1;
          bt_id[s] = bt_next_id;
          for (int a = 0; a < 3; a++) begin
            bt_lo[s][a] = td[32 + 32*a +: 32];
            bt_hi[s][a] = td[128 + 32*a +: 32];
          end
          bt_mass[s] = td[224 +: 32];
          r.assigned_id = bt_next_id;
          bt_next_id++;
        end
      end
      CMD_REMOVE: begin
        any = 1'b0;
        for (int i = 0; i < MAX_BODIES; i++)
          if (bt_valid[i] && bt_id[i] == td[31:0]) begin
            bt_valid[i] = 1'b0;
            any = 1'b1;
          end
        if (!any) r.status = ST_NOTFOUND;
      end
      CMD_UPDATE: begin
        s = find_body(td[31:0]);
        if (s < 0) r.status = ST_NOTFOUND;
        else
          for (int a = 0; a < 3; a++) begin
            bt_lo[s][a] = td[32 + 32*a +: 32];
            bt_hi[s][a] = td[128 + 32*a +: 32];
          end
      end
      default: begin
        s = find_body(td[31:0]);
        if (s < 0) r.status = ST_NOTFOUND;
        else r = separation_push(s);
      end
    endcase
    return r;
  endfunction

  // one beat on the input stream, prediction at acceptance; valid stays up
  // after the beat until the next one or an idle cycle replaces it
  task automatic send_beat(logic [1:0] cmd, logic [255:0] td);
    result_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= td;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_r = predict_body_cmd(cmd, td);
    expected_q.insert(expected_q.size(), exp_r);
  endtask

  function automatic logic [255:0] pack_box(logic [31:0] id, logic [31:0] lx,
      logic [31:0] ly, logic [31:0] lz, logic [31:0] hx, logic [31:0] hy,
      logic [31:0] hz, logic [31:0] m);
    return {m, hz, hy, hx, lz, ly, lx, id};
  endfunction

  // mostly small, overlapping boxes; sometimes any bits at all
  function automatic logic [255:0] rand_beat(logic [31:0] id);
    logic [31:0] lo [3];
    logic [31:0] hi [3];
    logic [31:0] m;
    if ($urandom_range(9) == 0)
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, id};
    for (int a = 0; a < 3; a++) begin
      lo[a] = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      hi[a] = lo[a] + $urandom_range(1, 6 << 16);
      if ($urandom_range(19) == 0) begin
        lo[a] = 32'h80000000 + $urandom_range(3);
        hi[a] = 32'h7fffffff - $urandom_range(3);
      end
    end
    case ($urandom_range(3))
      0: m = 32'd0;
      1: m = $urandom;
      default: m = $urandom_range(1, 8 << 16);
    endcase
    return pack_box(id, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], m);
  endfunction

  function automatic logic [31:0] pick_id();
    int s;
    s = $urandom_range(MAX_BODIES - 1);
    if (bt_valid[s] && $urandom_range(7) != 0) return bt_id[s];
    if ($urandom_range(1)) return bt_next_id - $urandom_range(1, 3);
    return $urandom;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver: random stall plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        m_axis_tready <= 1'b0;
      end else
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  initial begin
    result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          n_errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tuser !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, m_axis_tuser); n_errors++;
          end
          if (m_axis_tdata[31:0] !== exp_r.assigned_id) begin
            $error("assigned_id exp %h got %h", exp_r.assigned_id, m_axis_tdata[31:0]);
            n_errors++;
          end
          if (m_axis_tdata[63:32] !== exp_r.push_x) begin
            $error("push_x exp %h got %h", exp_r.push_x, m_axis_tdata[63:32]); n_errors++;
          end
          if (m_axis_tdata[95:64] !== exp_r.push_y) begin
            $error("push_y exp %h got %h", exp_r.push_y, m_axis_tdata[95:64]); n_errors++;
          end
          if (m_axis_tdata[127:96] !== exp_r.push_z) begin
            $error("push_z exp %h got %h", exp_r.push_z, m_axis_tdata[127:96]); n_errors++;
          end
        end
      end
    end
  end

  // directed: unknown ids, overlap cases, ties, zero mass, full table
  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    send_beat(CMD_QUERY,  pack_box(32'd0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(CMD_REMOVE, pack_box(32'hffffffff, 0, 0, 0, 0, 0, 0, 0));
    send_beat(CMD_UPDATE, pack_box(32'd5, 0, 0, 0, 0, 0, 0, 0));
    // two unit boxes, equal depths: tie to x, centres equal push plus
    send_beat(CMD_ADD, pack_box(0, 0, 0, 0, one, one, one, one));
    send_beat(CMD_ADD, pack_box(0, 0, 0, 0, one, one, one, one));
    send_beat(CMD_QUERY, pack_box(32'd0, 0, 0, 0, 0, 0, 0, 0));
    // shift body 1 along y: y is shallowest, sign minus for body 0
    send_beat(CMD_UPDATE, pack_box(32'd1, 0, one/2, 0, one, one + one/2, one, 0));
    send_beat(CMD_QUERY, pack_box(32'd0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(CMD_QUERY, pack_box(32'd1, 0, 0, 0, 0, 0, 0, 0));
    // touching only: no push
    send_beat(CMD_UPDATE, pack_box(32'd1, one, 0, 0, 2*one, one, one, 0));
    send_beat(CMD_QUERY, pack_box(32'd0, 0, 0, 0, 0, 0, 0, 0));
    // inverted box, extremes of the range
    send_beat(CMD_UPDATE, pack_box(32'd1, 32'h7fffffff, 0, 0, 32'h80000000, one, one, 0));
    send_beat(CMD_QUERY, pack_box(32'd1, 0, 0, 0, 0, 0, 0, 0));
    // huge boxes with mass extremes: saturation
    send_beat(CMD_UPDATE, pack_box(32'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    send_beat(CMD_UPDATE, pack_box(32'd1, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    for (int i = 0; i < MAX_BODIES; i++)
      send_beat(CMD_ADD, pack_box(0, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, (i % 2) ? 32'hffffffff : 32'd0));
    send_beat(CMD_QUERY, pack_box(32'd0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(CMD_QUERY, pack_box(32'd3, 0, 0, 0, 0, 0, 0, 0));
    send_beat(CMD_REMOVE, pack_box(32'd0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(CMD_REMOVE, pack_box(32'd0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random(int n_beats);
    logic [1:0] cmd;
    for (int n = 0; n < n_beats; n++) begin
      case ($urandom_range(9))
        0, 1, 2: cmd = CMD_ADD;
        3, 4:    cmd = CMD_REMOVE;
        5, 6:    cmd = CMD_UPDATE;
        default: cmd = CMD_QUERY;
      endcase
      send_beat(cmd, rand_beat(pick_id()));
    end
  endtask

  // receiver held off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_off_cycles = 3000;
    test_random(12);
    wait_drained();
  endtask

  initial begin
    n_errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;
    for (int i = 0; i < MAX_BODIES; i++) bt_valid[i] = 1'b0;
    bt_next_id = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(250); wait_drained();
    send_idle_pct = 62; recv_stall_pct = 0;  test_random(250); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 62; test_random(250); wait_drained();
    send_idle_pct = 14; recv_stall_pct = 14; test_random(250);
    test_backpressure();

    repeat (50) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: aabb_body_separation.f
rtl/aabbs_pkg.sv
rtl/aabbs_ram.sv
rtl/aabbs_ctrl.sv
rtl/aabbs_dp.sv
rtl/aabb_body_separation.sv
rtl/aabbs_checker.sv
bench/tb_aabb_body_separation.sv
